// File: hdl/nfc_frame_checker_defines.svh
// Assertion macros used by the checker file of the frame checker.
`ifndef NFC_FRAME_CHECKER_DEFINES_SVH
`define NFC_FRAME_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define NFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define NFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/nfc_fchk_pkg.sv
// Types and constants of the NFC frame checker.
package nfc_fchk_pkg;

  localparam int unsigned CountW = 9;

  localparam logic [CountW-1:0] CountMax       = 9'd511;
  localparam logic [CountW-1:0] FrameMinBytes  = 9'd9;
  localparam logic [CountW-1:0] FrameOverhead  = 9'd7;
  localparam logic [CountW-1:0] PosStartCode   = 9'd2;
  localparam logic [CountW-1:0] PosLength      = 9'd3;
  localparam logic [CountW-1:0] PosLengthCheck = 9'd4;
  localparam logic [CountW-1:0] PosFrameId     = 9'd5;

  localparam logic [7:0] StartCode      = 8'hFF;
  localparam logic [7:0] LengthMin      = 8'd2;
  localparam logic [7:0] FrameIdDefault = 8'hD5;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_PREAMBLE   = 3'd2,
    ST_START_CODE = 3'd3,
    ST_LEN_SMALL  = 3'd4,
    ST_LEN_SUM    = 3'd5,
    ST_TRUNCATED  = 3'd6,
    ST_DATA_SUM   = 3'd7
  } status_e;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } beat_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] payload_length;
  } verdict_t;

endpackage

// File: hdl/nfc_fchk_frame.sv
// Per-frame state of the NFC frame checker and the verdict logic.
module nfc_fchk_frame (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nfc_fchk_pkg::beat_t   beat_i,
  input  logic [7:0]            expected_frame_id_i,
  output nfc_fchk_pkg::verdict_t verdict_o
);

  logic [nfc_fchk_pkg::CountW-1:0] count_q, count_d;
  logic [7:0] len_q, len_d;
  logic [7:0] len_chk_q, len_chk_d;
  logic [7:0] sum_q, sum_d;
  logic       preamble_bad_q, preamble_bad_d;
  logic       start_bad_q, start_bad_d;
  logic       id_bad_q, id_bad_d;
  logic [7:0] len_total;
  logic [nfc_fchk_pkg::CountW-1:0] span_end;
  logic [nfc_fchk_pkg::CountW-1:0] min_count;

  assign span_end = {1'b0, len_q} + nfc_fchk_pkg::PosFrameId;

  always_comb begin
    count_d        = count_q;
    len_d          = len_q;
    len_chk_d      = len_chk_q;
    sum_d          = sum_q;
    preamble_bad_d = preamble_bad_q;
    start_bad_d    = start_bad_q;
    id_bad_d       = id_bad_q;

    if (count_q < nfc_fchk_pkg::PosStartCode) begin
      if (beat_i.data != 8'd0) begin
        preamble_bad_d = 1'b1;
      end
    end else if (count_q == nfc_fchk_pkg::PosStartCode) begin
      start_bad_d = (beat_i.data != nfc_fchk_pkg::StartCode);
    end else if (count_q == nfc_fchk_pkg::PosLength) begin
      len_d = beat_i.data;
    end else if (count_q == nfc_fchk_pkg::PosLengthCheck) begin
      len_chk_d = beat_i.data;
    end else if (count_q <= span_end) begin
      sum_d = sum_q + beat_i.data;
      if (count_q == nfc_fchk_pkg::PosFrameId) begin
        id_bad_d = (beat_i.data != expected_frame_id_i);
      end
    end

    if (count_q != nfc_fchk_pkg::CountMax) begin
      count_d = count_q + 1'b1;
    end
  end

  // The verdict looks at the state as it stands after the current byte.
  assign len_total = len_d + len_chk_d;
  assign min_count = {1'b0, len_d} + nfc_fchk_pkg::FrameOverhead;

  always_comb begin
    verdict_o.payload_length = 8'd0;
    if (count_d < nfc_fchk_pkg::FrameMinBytes) begin
      verdict_o.status = nfc_fchk_pkg::ST_SHORT;
    end else if (preamble_bad_d) begin
      verdict_o.status = nfc_fchk_pkg::ST_PREAMBLE;
    end else if (start_bad_d) begin
      verdict_o.status = nfc_fchk_pkg::ST_START_CODE;
    end else if (len_d < nfc_fchk_pkg::LengthMin) begin
      verdict_o.status = nfc_fchk_pkg::ST_LEN_SMALL;
    end else if (len_total != 8'd0) begin
      verdict_o.status = nfc_fchk_pkg::ST_LEN_SUM;
    end else if (count_d < min_count) begin
      verdict_o.status = nfc_fchk_pkg::ST_TRUNCATED;
    end else if ((sum_d != 8'd0) || id_bad_d) begin
      verdict_o.status = nfc_fchk_pkg::ST_DATA_SUM;
    end else begin
      verdict_o.status         = nfc_fchk_pkg::ST_OK;
      verdict_o.payload_length = len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      len_q          <= '0;
      len_chk_q      <= '0;
      sum_q          <= '0;
      preamble_bad_q <= 1'b0;
      start_bad_q    <= 1'b0;
      id_bad_q       <= 1'b0;
    end else if (beat_i.valid) begin
      if (beat_i.last) begin
        count_q        <= '0;
        len_q          <= '0;
        len_chk_q      <= '0;
        sum_q          <= '0;
        preamble_bad_q <= 1'b0;
        start_bad_q    <= 1'b0;
        id_bad_q       <= 1'b0;
      end else begin
        count_q        <= count_d;
        len_q          <= len_d;
        len_chk_q      <= len_chk_d;
        sum_q          <= sum_d;
        preamble_bad_q <= preamble_bad_d;
        start_bad_q    <= start_bad_d;
        id_bad_q       <= id_bad_d;
      end
    end
  end

endmodule

// File: hdl/nfc_frame_checker.sv
// Top level of the byte-serial NFC controller frame checker.
//
//   Channel  Handshake                  Payload
//   in       in_valid_i / in_ready_o    data_byte_i[7:0], last_byte_i
//   out      out_valid_o / out_ready_i  status_o[2:0], payload_length_o[7:0]
//   cfg      cfg_valid_i / cfg_ready_o  expected_frame_id_i[7:0]
//
// One byte is taken per cycle while no last byte waits on a stalled result.
// A byte goes into an input register and updates the frame state when it moves
// on; a last byte loads its verdict into the output register as it moves on, so
// the result is registered in the input register and then the output register.
// Reset clears the frame state and sets the expected identifier to 0xD5.
// Only last bytes wait on a full, stalled output register; other bytes pass.
module nfc_frame_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic [7:0] payload_length_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] expected_frame_id_i
);

  logic       in_valid_q;
  logic       in_last_q;
  logic [7:0] in_data_q;
  logic       advance;
  logic [7:0] frame_id_q;
  logic       out_valid_q;
  logic [2:0] status_q;
  logic [7:0] length_q;

  nfc_fchk_pkg::beat_t    beat;
  nfc_fchk_pkg::verdict_t verdict;

  // A held byte moves on unless it closes a frame while the result slot is blocked.
  assign advance    = in_valid_q && (!in_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  assign beat.valid = advance;
  assign beat.last  = in_last_q;
  assign beat.data  = in_data_q;

  nfc_fchk_frame u_frame (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .beat_i              (beat),
    .expected_frame_id_i (frame_id_q),
    .verdict_o           (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_id_q <= nfc_fchk_pkg::FrameIdDefault;
    end else if (cfg_valid_i && cfg_ready_o) begin
      frame_id_q <= expected_frame_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      status_q <= verdict.status;
      length_q <= verdict.payload_length;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign payload_length_o = length_q;

endmodule

// File: hdl/nfc_fchk_checker.sv
// Port-level assertions for the NFC frame checker, bound to the top level.
`include "nfc_frame_checker_defines.svh"

module nfc_fchk_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] status_o,
  input logic [7:0] payload_length_o
);

  logic out_stall;
  logic status_ok;
  logic len_low;

  assign out_stall = out_valid_o && !out_ready_i;
  assign status_ok = (status_o == nfc_fchk_pkg::ST_OK);
  assign len_low   = (payload_length_o < nfc_fchk_pkg::LengthMin);

  // A stalled result keeps its transaction on the port.
  `NFC_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o, "result dropped while stalled")
  `NFC_ASSERT_NEXT(a_out_stable, out_stall, $stable({status_o, payload_length_o}), "result changed")

  // The length is reported only for a good frame, and a good frame reports a length of at least two.
  `NFC_ASSERT_NOW(a_len_zero, out_valid_o && !status_ok, payload_length_o == 8'd0, "length on failed frame")
  `NFC_ASSERT_NOW(a_len_min, out_valid_o && status_ok, !len_low, "good frame with length below two")

endmodule

bind nfc_frame_checker nfc_fchk_checker u_nfc_fchk_checker (.*);

// File: dv/tb_nfc_frame_checker.sv
// Self-checking testbench for the NFC frame checker, with a frame predictor, directed and random frames.
`timescale 1ns / 100ps

module tb_nfc_frame_checker;
  import nfc_fchk_pkg::*;

  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned BytesPerPhase = 110;

  // Predicts the verdict of each frame and holds the verdicts still owed by the block.
  class frame_verdict_board;
    logic [7:0]        frame_id;
    logic [CountW-1:0] byte_count;
    logic [7:0]        len_byte;
    logic [7:0]        len_check;
    logic [7:0]        span_sum;
    bit                preamble_bad;
    bit                start_bad;
    bit                id_bad;
    verdict_t          pending_q[$];
    int unsigned       errors;
    int unsigned       verdicts;
    int unsigned       per_status[8];

    function new();
      frame_id = FrameIdDefault;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_count   = '0;
      len_byte     = '0;
      len_check    = '0;
      span_sum     = '0;
      preamble_bad = 1'b0;
      start_bad    = 1'b0;
      id_bad       = 1'b0;
    endfunction

    function status_e judge();
      if (byte_count < FrameMinBytes) return ST_SHORT;
      if (preamble_bad) return ST_PREAMBLE;
      if (start_bad) return ST_START_CODE;
      if (len_byte < LengthMin) return ST_LEN_SMALL;
      if (8'(len_byte + len_check) != 8'd0) return ST_LEN_SUM;
      if (byte_count < {1'b0, len_byte} + FrameOverhead) return ST_TRUNCATED;
      if (span_sum != 8'd0 || id_bad) return ST_DATA_SUM;
      return ST_OK;
    endfunction

    // Called for every accepted byte transaction.
    function void note_byte(logic [7:0] b, logic l);
      status_e st;
      if (byte_count < PosStartCode) begin
        if (b != 8'd0) preamble_bad = 1'b1;
      end else if (byte_count == PosStartCode) begin
        start_bad = (b != StartCode);
      end else if (byte_count == PosLength) begin
        len_byte = b;
      end else if (byte_count == PosLengthCheck) begin
        len_check = b;
      end else if (byte_count <= PosFrameId + {1'b0, len_byte}) begin
        span_sum = span_sum + b;
        if (byte_count == PosFrameId) id_bad = (b != frame_id);
      end
      if (byte_count != CountMax) byte_count = byte_count + 1'b1;
      if (l) begin
        st = judge();
        pending_q.push_back('{status: st, payload_length: (st == ST_OK) ? len_byte : 8'd0});
        clear_frame();
      end
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_verdict(logic [2:0] st, logic [7:0] plen);
      verdict_t exp_v;
      if (pending_q.size() == 0) begin
        report($sformatf("verdict status %0d length %0d with none expected", st, plen));
        return;
      end
      exp_v = pending_q.pop_front();
      verdicts++;
      per_status[exp_v.status]++;
      if (st !== exp_v.status)
        report($sformatf("verdict %0d: status %0d, expected %s", verdicts, st,
                         exp_v.status.name()));
      if (plen !== exp_v.payload_length)
        report($sformatf("verdict %0d: payload length %0d, expected %0d", verdicts, plen,
                         exp_v.payload_length));
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] data_byte_i;
  logic       last_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [2:0] status_o;
  logic [7:0] payload_length_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [7:0] expected_frame_id_i;

  frame_verdict_board board = new();
  logic [7:0]  frame_q[$];
  logic [7:0]  cur_frame_id = FrameIdDefault;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned bytes_sent   = 0;
  int unsigned frames_sent  = 0;
  int unsigned cycle_cnt    = 0;
  logic        rx_hold;
  event        hold_ev;

  nfc_frame_checker dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .data_byte_i        (data_byte_i),
    .last_byte_i        (last_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .payload_length_o   (payload_length_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .expected_frame_id_i(expected_frame_id_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d verdicts outstanding", cycle_cnt,
               board.pending_q.size());
      $display("** nfc_frame_checker: FAILED **");
      $finish;
    end
  end

  // Result side: check each verdict transaction, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) board.check_verdict(status_o, payload_length_o);
      if (rx_hold) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps running meanwhile.
  initial begin
    rx_hold = 1'b0;
    forever begin
      @(hold_ev);
      rx_hold = 1'b1;
      repeat (HoldOffCycles) @(posedge clk_i);
      rx_hold = 1'b0;
    end
  end

  task automatic push_byte(logic [7:0] b, logic l);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= l;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_byte(b, l);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) push_byte(frame_q[i], i == frame_q.size() - 1);
    frames_sent++;
  endtask

  // Well-formed frame: preamble, start code, length and its checksum, identifier,
  // data, data checksum, then trailing bytes that fall outside the checksummed span.
  task automatic build_frame(logic [7:0] len, logic [7:0] id, int unsigned trail);
    logic [7:0] sum;
    logic [7:0] b;
    frame_q.delete();
    frame_q.push_back(8'd0);
    frame_q.push_back(8'd0);
    frame_q.push_back(StartCode);
    frame_q.push_back(len);
    frame_q.push_back(8'(8'd0 - len));
    frame_q.push_back(id);
    sum = id;
    if (len != 8'd0) begin
      for (int i = 1; i < len; i++) begin
        b = 8'($urandom);
        frame_q.push_back(b);
        sum = sum + b;
      end
      frame_q.push_back(8'(8'd0 - sum));
    end
    repeat (trail) frame_q.push_back(8'($urandom));
  endtask

  task automatic send_random_frame();
    logic [7:0]  len;
    logic [7:0]  flip;
    int unsigned pick;
    int unsigned keep;
    bit          trunc;
    bit          noise;
    pick = $urandom_range(99);
    if (pick < 2) len = 8'd255;
    else if (pick < 6) len = 8'($urandom_range(1));
    else if (pick < 16) len = 8'($urandom_range(60, 13));
    else len = 8'($urandom_range(12, 2));
    build_frame(len, cur_frame_id, $urandom_range(3, 1));
    trunc = 1'b0;
    noise = 1'b0;
    // Most frames go through clean; the rest carry one or two faults so that
    // the verdict priority gets exercised.
    if ($urandom_range(99) < 40) begin
      repeat ($urandom_range(2, 1)) begin
        flip = 8'($urandom_range(255, 1));
        case ($urandom_range(8))
          0: frame_q[$urandom_range(1)] ^= flip;
          1: frame_q[PosStartCode] ^= flip;
          2: frame_q[PosLength] ^= flip;
          3: frame_q[PosLengthCheck] ^= flip;
          4: frame_q[PosFrameId] ^= flip;
          5: frame_q[$urandom_range(PosFrameId + len, PosFrameId)] ^= flip;
          6: repeat ($urandom_range(20)) frame_q.push_back(8'($urandom));
          7: trunc = 1'b1;
          default: noise = 1'b1;
        endcase
      end
    end
    if (noise) begin
      frame_q.delete();
      repeat ($urandom_range(24, 1)) frame_q.push_back(8'($urandom));
    end
    if (trunc) begin
      keep = $urandom_range(frame_q.size() - 1, 1);
      while (frame_q.size() > keep) void'(frame_q.pop_back());
    end
    send_frame();
  endtask

  // Stops the sender until every owed verdict is in and the pipeline is empty.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_frame_id(logic [7:0] id);
    cfg_valid_i         <= 1'b1;
    expected_frame_id_i <= id;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i    <= 1'b0;
    board.frame_id = id;
    cur_frame_id   = id;
  endtask

  initial begin
    logic [7:0]  id_plan[4];
    int unsigned phase_start;
    rst_ni              = 1'b0;
    in_valid_i          = 1'b0;
    data_byte_i         = 8'd0;
    last_byte_i         = 1'b0;
    out_ready_i         = 1'b0;
    cfg_valid_i         = 1'b0;
    expected_frame_id_i = 8'd0;
    id_plan[0] = 8'h00;
    id_plan[1] = 8'hFF;
    id_plan[2] = 8'($urandom_range(255));
    id_plan[3] = FrameIdDefault;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a one-byte frame, a minimal good frame under the reset identifier,
    // and a frame with an all-ones preamble.
    push_byte(8'hFF, 1'b1);
    build_frame(LengthMin, FrameIdDefault, 1);
    send_frame();
    build_frame(LengthMin, FrameIdDefault, 1);
    frame_q[0] = 8'hFF;
    frame_q[1] = 8'hFF;
    send_frame();

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 59; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 59; end
        default: begin tx_idle_pct = 18; rx_stall_pct = 18; end
      endcase
      write_frame_id(id_plan[ph]);
      if (ph == 0) -> hold_ev;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < BytesPerPhase) send_random_frame();
      // One frame long enough to run the byte counter into saturation.
      if (ph == 3) begin
        build_frame(8'd5, cur_frame_id, 530);
        send_frame();
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d frames (%0d bytes) under identifiers 00, FF, %02h and D5, with idle,",
             frames_sent, bytes_sent, id_plan[2]);
    $display("stall and hold-off mixes; verdicts ok..data-sum: %0d %0d %0d %0d %0d %0d %0d %0d",
             board.per_status[0], board.per_status[1], board.per_status[2],
             board.per_status[3], board.per_status[4], board.per_status[5],
             board.per_status[6], board.per_status[7]);
    if (board.errors == 0) begin
      $display("** nfc_frame_checker: PASSED **");
    end else begin
      $display("** nfc_frame_checker: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/nfc_fchk_pkg.sv
hdl/nfc_fchk_frame.sv
hdl/nfc_frame_checker.sv
hdl/nfc_fchk_checker.sv
dv/tb_nfc_frame_checker.sv
